>>> design/insertion_sort_records_by_key_core_assert.svh
// Assertion macros used by the checker of this block.
`ifndef INSERTION_SORT_RECORDS_BY_KEY_CORE_ASSERT_SVH
`define INSERTION_SORT_RECORDS_BY_KEY_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define ISRK_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("isrk assertion failed");

// Next-cycle implication, disabled during reset.
`define ISRK_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("isrk assertion failed");

`endif

>>> design/isrk_pkg.sv
package isrk_pkg;

   localparam int KEY_WIDTH = 16;
   localparam int TAG_WIDTH = 16;

   typedef struct packed {
      logic [KEY_WIDTH-1:0] record_key;
      logic [TAG_WIDTH-1:0] record_tag;
      logic                 final_record;
   } req_payload_type;

   typedef struct packed {
      logic [KEY_WIDTH-1:0] sorted_key;
      logic [TAG_WIDTH-1:0] sorted_tag;
      logic                 last_out;
      logic                 overflow;
   } rsp_payload_type;

   typedef struct packed {
      logic [KEY_WIDTH-1:0] key;
      logic [TAG_WIDTH-1:0] tag;
   } entry_type;

   // controller to datapath
   typedef struct packed {
      logic load;        // latch request, start position at end of store
      logic rd_prev;     // read entry below current position
      logic shift;       // move read entry up into current position
      logic place;       // write new record at current position
      logic emit_start;  // rewind position for emission
      logic rd_pos;      // read entry at current position
      logic emit_load;   // load output register, advance position
      logic clear;       // empty the store
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic full;
      logic pos_zero;
      logic greater;
      logic final_rec;
      logic emit_done;
   } status_type;

endpackage

>>> design/isrk_if.sv
interface isrk_req_if;
   logic                     valid;
   logic                     ready;
   isrk_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface isrk_rsp_if;
   logic                     valid;
   logic                     ready;
   isrk_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> design/insertion_sort_records_by_key_core.sv
// Insertion: after a request transfer the controller shifts s entries up (0 .. DEPTH-1),
// one store read and one write per shift, then places the record; a record that meets a
// full store is dropped without shifts. Ready then returns.
// Emission: each result is read from the store, loaded into the output register and held
// until the sink takes it; results go out one at a time through the single store read port.
// Reset (synchronous, active high): store empty, overflow clear, ready high; contents kept.
module insertion_sort_records_by_key_core #(
   parameter int DEPTH = 64
) (
   input  logic              clock,
   input  logic              reset,
   isrk_req_if.sink          req_chan,
   isrk_rsp_if.source        rsp_chan
);
   import isrk_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Controller: sequences the shift loop of each insertion (read entry below,
   // compare, move it up) and the emission walk, one result transfer at a time.
   // No request is taken while a run is being emitted.
   isrk_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: the record store (one write, one registered read per cycle),
   // insertion position, fill count, overflow flag and output register.
   // A record arriving with the store full is dropped and sets the flag;
   // a final record still starts emission of what was kept.
   // Only strictly greater keys move up, so equal keys keep arrival order.
   isrk_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_chan.payload),
      .rsp_payload (rsp_chan.payload),
      .cmd         (cmd),
      .status      (status)
   );

endmodule

>>> design/isrk_ctrl.sv
module isrk_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  isrk_pkg::status_type   status,
   output isrk_pkg::cmd_type      cmd
);
   import isrk_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_COMPARE,
      ST_DONE_INS,
      ST_EMIT_RD,
      ST_EMIT_LOAD,
      ST_EMIT_WAIT
   } state_type;

   state_type state_ff, state_in;
   logic      req_ready_ff, req_ready_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      req_ready_in = req_ready_ff;
      rsp_valid_in = rsp_valid_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready_ff) begin
               cmd.load     = 1'b1;
               req_ready_in = 1'b0;
               state_in     = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.full) begin
               state_in = ST_DONE_INS;
            end else if (status.pos_zero) begin
               cmd.place = 1'b1;
               state_in  = ST_DONE_INS;
            end else begin
               cmd.rd_prev = 1'b1;
               state_in    = ST_COMPARE;
            end
         end
         ST_COMPARE: begin
            if (status.greater) begin
               cmd.shift = 1'b1;
               state_in  = ST_CHECK;
            end else begin
               cmd.place = 1'b1;
               state_in  = ST_DONE_INS;
            end
         end
         ST_DONE_INS: begin
            if (status.final_rec) begin
               cmd.emit_start = 1'b1;
               state_in       = ST_EMIT_RD;
            end else begin
               req_ready_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_EMIT_RD: begin
            cmd.rd_pos = 1'b1;
            state_in   = ST_EMIT_LOAD;
         end
         ST_EMIT_LOAD: begin
            cmd.emit_load = 1'b1;
            rsp_valid_in  = 1'b1;
            state_in      = ST_EMIT_WAIT;
         end
         ST_EMIT_WAIT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (status.emit_done) begin
                  cmd.clear    = 1'b1;
                  req_ready_in = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  state_in = ST_EMIT_RD;
               end
            end
         end
         default: begin
            req_ready_in = 1'b1;
            rsp_valid_in = 1'b0;
            state_in     = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         req_ready_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_ready_ff <= req_ready_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

>>> design/isrk_datapath.sv
module isrk_datapath #(
   parameter int DEPTH = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  isrk_pkg::req_payload_type   req_payload,
   output isrk_pkg::rsp_payload_type   rsp_payload,
   input  isrk_pkg::cmd_type           cmd,
   output isrk_pkg::status_type        status
);
   import isrk_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   entry_type            store_ff [DEPTH];
   entry_type            rd_data_ff;
   entry_type            wr_data;
   logic [AW-1:0]        wr_addr;
   logic [AW-1:0]        rd_addr;
   logic                 mem_we;
   logic                 mem_re;

   logic [KEY_WIDTH-1:0] key_ff;
   logic [TAG_WIDTH-1:0] tag_ff;
   logic                 final_ff;
   logic [CW-1:0]        pos_ff, pos_in;
   logic [CW-1:0]        count_ff, count_in;
   logic                 ovf_ff, ovf_in;
   rsp_payload_type      rsp_ff;
   logic [CW-1:0]        pos_dec;
   logic [CW-1:0]        pos_inc;
   logic                 full;

   assign pos_dec = pos_ff - CW'(1);
   assign pos_inc = pos_ff + CW'(1);
   assign full    = (count_ff == CW'(DEPTH));

   assign mem_we  = cmd.shift || cmd.place;
   assign mem_re  = cmd.rd_prev || cmd.rd_pos;
   assign wr_addr = pos_ff[AW-1:0];
   assign rd_addr = cmd.rd_prev ? pos_dec[AW-1:0] : pos_ff[AW-1:0];
   assign wr_data = cmd.shift ? rd_data_ff : entry_type'({key_ff, tag_ff});

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (mem_re) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   always_comb begin
      pos_in   = pos_ff;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      if (cmd.load) begin
         pos_in = count_ff;
         if (full) begin
            ovf_in = 1'b1;
         end
      end
      if (cmd.shift) begin
         pos_in = pos_dec;
      end
      if (cmd.place) begin
         count_in = count_ff + CW'(1);
      end
      if (cmd.emit_start) begin
         pos_in = '0;
      end
      if (cmd.emit_load) begin
         pos_in = pos_inc;
      end
      if (cmd.clear) begin
         count_in = '0;
         ovf_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         key_ff   <= req_payload.record_key;
         tag_ff   <= req_payload.record_tag;
         final_ff <= req_payload.final_record;
      end
      if (cmd.emit_load) begin
         rsp_ff.sorted_key <= rd_data_ff.key;
         rsp_ff.sorted_tag <= rd_data_ff.tag;
         rsp_ff.last_out   <= (pos_inc == count_ff);
         rsp_ff.overflow   <= ovf_ff;
      end
   end

   assign rsp_payload      = rsp_ff;
   assign status.full      = full;
   assign status.pos_zero  = (pos_ff == '0);
   assign status.greater   = (rd_data_ff.key > key_ff);
   assign status.final_rec = final_ff;
   assign status.emit_done = (pos_ff == count_ff);

endmodule

>>> design/isrk_checker.sv
`include "insertion_sort_records_by_key_core_assert.svh"

module isrk_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input isrk_pkg::rsp_payload_type rsp_payload
);

   // no request taken while a result is offered
   `ISRK_ASSERT_NOW(a_no_overlap, clock, reset, req_ready, !rsp_valid)

   // each request transfer drops ready in the next cycle
   `ISRK_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)

   // the final result of a run ends the run
   `ISRK_ASSERT_NEXT(a_last_ends_run, clock, reset,
      rsp_valid && rsp_ready && rsp_payload.last_out, !rsp_valid)

   // a stalled result holds
   `ISRK_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_payload))

endmodule

bind insertion_sort_records_by_key_core isrk_checker u_isrk_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_payload (rsp_chan.payload)
);
